// ===== rtl/fqg_pkg.sv =====
// Shared types and constants for the frame quality gate.
// No dependencies; the other RTL files except fqg_if refer to it by scoped names.
package fqg_pkg;

  // Configuration port geometry
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_MIN_BRIGHTNESS = 3'd2;
  localparam logic [2:0] REG_MAX_BRIGHTNESS = 3'd3;
  localparam logic [2:0] REG_MIN_BLUR       = 3'd4;
  localparam logic [2:0] REG_CONF_LOW       = 3'd5;
  localparam logic [2:0] REG_CONF_HIGH      = 3'd6;

  // Register reset values
  localparam logic [10:0] RST_FRAME_WIDTH    = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT   = 11'd480;
  localparam logic [7:0]  RST_MIN_BRIGHTNESS = 8'd40;
  localparam logic [7:0]  RST_MAX_BRIGHTNESS = 8'd220;
  localparam logic [19:0] RST_MIN_BLUR       = 20'd100;
  localparam logic [15:0] RST_CONF_LOW       = 16'd26214;
  localparam logic [15:0] RST_CONF_HIGH      = 16'd39322;

  // Item kinds
  localparam logic CMD_DETECTION = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  // Gray conversion, Q14 weights plus rounding
  localparam logic [21:0] GRAY_K_RED   = 22'd4899;
  localparam logic [21:0] GRAY_K_GREEN = 22'd9617;
  localparam logic [21:0] GRAY_K_BLUE  = 22'd1868;
  localparam logic [21:0] GRAY_ROUND   = 22'd8192;

  typedef enum logic [2:0] {
    REASON_CLEAR       = 3'd0,
    REASON_UNCERTAIN   = 3'd1,
    REASON_TOO_DARK    = 3'd2,
    REASON_TOO_BRIGHT  = 3'd3,
    REASON_BLURRY      = 3'd4
  } reason_t;

  // Line store lanes used by one Laplacian row sweep
  typedef struct packed {
    logic [1:0] up;
    logic [1:0] mid;
    logic [1:0] dn;
  } sweep_rows_t;

  // Verdict from the end-of-frame arithmetic
  typedef struct packed {
    logic done;
    logic dark;
    logic bright;
    logic blurry;
  } verdict_t;

endpackage

// ===== rtl/fqg_if.sv =====
// Valid/ready channel interfaces for items in and frame results out.
// Depends on nothing; used by the top level ports.
interface fqg_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] det_conf;
  logic [7:0]  pixel_blue;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_red;

  modport source (output valid, cmd, det_conf, pixel_blue, pixel_green, pixel_red,
                  input ready);
  modport sink   (input valid, cmd, det_conf, pixel_blue, pixel_green, pixel_red,
                  output ready);
endinterface

interface fqg_out_if;
  logic        valid;
  logic        ready;
  logic        save_frame;
  logic [2:0]  reason_code;
  logic [15:0] flagged_conf;

  modport source (output valid, save_frame, reason_code, flagged_conf, input ready);
  modport sink   (input valid, save_frame, reason_code, flagged_conf, output ready);
endinterface

// ===== rtl/fqg_lap.sv =====
// Three-row gray line store and the Laplacian row sweep with its running sums.
// Depends on fqg_pkg (sweep_rows_t).
module fqg_lap #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [1:0]                   wr_slot,
  input  logic [7:0]                   wr_data,
  input  logic                         go,
  input  fqg_pkg::sweep_rows_t         rows,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] width,
  input  logic                         clear,
  output logic                         done,
  output logic signed [$clog2(MAX_WIDTH*MAX_HEIGHT+1)+10:0] lap_sum,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)+19:0]        lap_sq,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]         lap_cnt
);

  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LSW = NW + 11;
  localparam int QW  = NW + 20;

  // One word per column, one byte lane per row slot
  logic [2:0][7:0] line_mem [MAX_WIDTH];
  logic [2:0][7:0] rd_q;

  logic                 issue_r, rv_r, rlast_r, have_r, first_r, tail_r;
  logic [CAW-1:0]       ic_r;
  logic [WW-1:0]        wl_r;
  fqg_pkg::sweep_rows_t rows_r;
  logic [7:0]           prev_m_r, cur_u_r, cur_m_r, cur_d_r;
  logic signed [11:0]   v_r;
  logic                 v_vld_r, v_last_r;
  logic [19:0]          sq_r;
  logic                 sq_vld_r, sq_last_r, done_r;
  logic signed [LSW-1:0] sum_r;
  logic [QW-1:0]        sqt_r;
  logic [NW-1:0]        cnt_r;

  logic               ic_last, eval_en;
  logic [7:0]         nxt_u, nxt_m, nxt_d, lft, rgt;
  logic signed [11:0] v_calc;
  logic signed [23:0] sq_full;

  // Memory ports: byte-lane write, registered word read
  always_ff @(posedge clk) begin
    if (wr_en) line_mem[wr_addr][wr_slot] <= wr_data;
    if (issue_r) rd_q <= line_mem[ic_r];
  end

  assign ic_last = (ic_r == CAW'(wl_r - WW'(1)));
  assign nxt_u   = rd_q[rows_r.up];
  assign nxt_m   = rd_q[rows_r.mid];
  assign nxt_d   = rd_q[rows_r.dn];
  assign eval_en = (rv_r && have_r) || tail_r;

  // Reflect-101 edges: first column mirrors the right neighbor, last the left
  assign lft = first_r ? nxt_m : prev_m_r;
  assign rgt = tail_r ? prev_m_r : nxt_m;
  assign v_calc = $signed({4'b0, cur_u_r}) + $signed({4'b0, cur_d_r})
                + $signed({4'b0, lft}) + $signed({4'b0, rgt})
                - $signed({2'b0, cur_m_r, 2'b0});
  assign sq_full = v_r * v_r;

  // Sweep control and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r  <= 1'b0;
      rv_r     <= 1'b0;
      rlast_r  <= 1'b0;
      have_r   <= 1'b0;
      tail_r   <= 1'b0;
      v_vld_r  <= 1'b0;
      v_last_r <= 1'b0;
      sq_vld_r <= 1'b0;
      sq_last_r <= 1'b0;
      done_r   <= 1'b0;
      ic_r     <= '0;
    end else begin
      rv_r     <= issue_r;
      rlast_r  <= issue_r && ic_last;
      tail_r   <= rv_r && rlast_r;
      v_vld_r  <= eval_en;
      v_last_r <= tail_r;
      sq_vld_r <= v_vld_r;
      sq_last_r <= v_last_r;
      done_r   <= sq_vld_r && sq_last_r;
      if (go) begin
        issue_r <= 1'b1;
        ic_r    <= '0;
      end else if (issue_r) begin
        ic_r <= ic_r + CAW'(1);
        if (ic_last) issue_r <= 1'b0;
      end
      if (rv_r) have_r <= 1'b1;
      else if (tail_r) have_r <= 1'b0;
    end
  end

  // Sliding window and Laplacian datapath
  always_ff @(posedge clk) begin
    if (go) begin
      wl_r   <= width;
      rows_r <= rows;
    end
    if (rv_r) begin
      prev_m_r <= cur_m_r;
      cur_u_r  <= nxt_u;
      cur_m_r  <= nxt_m;
      cur_d_r  <= nxt_d;
      first_r  <= !have_r;
    end
    if (eval_en) v_r <= v_calc;
    if (v_vld_r) sq_r <= sq_full[19:0];
  end

  // Frame sums
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_r <= '0;
      sqt_r <= '0;
      cnt_r <= '0;
    end else begin
      if (v_vld_r) begin
        sum_r <= sum_r + LSW'(v_r);
        cnt_r <= cnt_r + NW'(1);
      end
      if (sq_vld_r) sqt_r <= sqt_r + QW'(sq_r);
    end
  end

  assign done    = done_r;
  assign lap_sum = sum_r;
  assign lap_sq  = sqt_r;
  assign lap_cnt = cnt_r;

  a_go_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !issue_r && !rv_r && !tail_r && !v_vld_r && !sq_vld_r)
    else $error("sweep started while one is in flight");
  a_tail_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r |-> have_r && !issue_r)
    else $error("tail column without loaded window");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("sweep done held");

endmodule

// ===== rtl/fqg_decide.sv =====
// End-of-frame brightness and blur verdict on one shared shift-add multiplier.
// Depends on fqg_pkg (verdict_t).
module fqg_decide #(
  parameter int NW = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [NW+7:0]         gray_total,
  input  logic [NW-1:0]         gray_cnt,
  input  logic signed [NW+10:0] lap_sum,
  input  logic [NW+19:0]        lap_sq,
  input  logic [NW-1:0]         lap_cnt,
  input  logic [7:0]            min_bright,
  input  logic [7:0]            max_bright,
  input  logic [19:0]           min_blur,
  output fqg_pkg::verdict_t     verdict
);

  localparam int AW = 2 * NW + 20;
  localparam int BW = (NW + 10 > 20) ? NW + 10 : 20;

  typedef enum logic [6:0] {
    D_IDLE   = 7'b0000001,
    D_DARK   = 7'b0000010,
    D_BRIGHT = 7'b0000100,
    D_T1     = 7'b0001000,
    D_T2     = 7'b0010000,
    D_T3     = 7'b0100000,
    D_RHS    = 7'b1000000
  } dstate_t;

  dstate_t          state_r, state_nxt;
  logic [AW-1:0]    ma_r, acc_r, diff_r;
  logic [BW-1:0]    mb_r;
  logic             dark_r, bright_r, blurry_r, done_r;
  logic             mul_fin;
  logic signed [NW+10:0] neg_sum;
  logic [NW+9:0]    abs_sum;

  assign mul_fin = (mb_r == '0);
  assign neg_sum = (lap_sum < 0) ? -lap_sum : lap_sum;
  assign abs_sum = neg_sum[NW+9:0];

  // Sequencer: one product after another
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE:   if (go) state_nxt = D_DARK;
      D_DARK:   if (mul_fin) state_nxt = D_BRIGHT;
      D_BRIGHT: if (mul_fin) state_nxt = D_T1;
      D_T1:     if (mul_fin) state_nxt = D_T2;
      D_T2:     if (mul_fin) state_nxt = D_T3;
      D_T3:     if (mul_fin) state_nxt = D_RHS;
      D_RHS:    if (mul_fin) state_nxt = D_IDLE;
      default:  state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == D_RHS) && mul_fin;
    end
  end

  // Multiplier step, or store the product and load the next operands
  always_ff @(posedge clk) begin
    if (state_r != D_IDLE && !mul_fin) begin
      acc_r <= acc_r + (mb_r[0] ? ma_r : '0);
      ma_r  <= ma_r << 1;
      mb_r  <= mb_r >> 1;
    end else begin
      acc_r <= '0;
      unique case (state_r)
        D_IDLE: begin
          ma_r <= AW'(gray_cnt);
          mb_r <= BW'(min_bright);
        end
        D_DARK: begin
          dark_r <= AW'(gray_total) < acc_r;
          ma_r   <= AW'(gray_cnt);
          mb_r   <= BW'(max_bright);
        end
        D_BRIGHT: begin
          bright_r <= AW'(gray_total) > acc_r;
          ma_r     <= AW'(lap_sq);
          mb_r     <= BW'(lap_cnt);
        end
        D_T1: begin
          diff_r <= acc_r;
          ma_r   <= AW'(abs_sum);
          mb_r   <= BW'(abs_sum);
        end
        D_T2: begin
          diff_r <= diff_r - acc_r;
          ma_r   <= AW'(lap_cnt);
          mb_r   <= BW'(lap_cnt);
        end
        D_T3: begin
          ma_r <= acc_r;
          mb_r <= BW'(min_blur);
        end
        D_RHS: begin
          blurry_r <= diff_r < acc_r;
        end
        default: begin
          ma_r <= '0;
          mb_r <= '0;
        end
      endcase
    end
  end

  assign verdict.done   = done_r;
  assign verdict.dark   = dark_r;
  assign verdict.bright = bright_r;
  assign verdict.blurry = blurry_r;

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> state_r == D_IDLE)
    else $error("verdict requested while busy");
  a_done_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == D_IDLE)
    else $error("done without return to idle");
  a_done_after_rhs: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) == D_RHS)
    else $error("done from wrong step");

endmodule

// ===== rtl/frame_quality_gate.sv =====
// Top level: config registers, item intake, frame counters and result register.
// Depends on fqg_pkg, fqg_if, fqg_lap and fqg_decide.
//
// Usage: detection items (cmd 0) and BGR pixels (cmd 1, raster order) enter on
// in_ch; one result per finished frame leaves on out_ch. Registers must be written
// over the APB port only while the block is idle; the block itself does not
// enforce this. Reads return the stored values. Throughput: one item per cycle
// inside a row. At the end of each row after the first, in_ch.ready drops for
// a Laplacian sweep of the line store, which makes one read per column through
// the single read port of the line memory. At frame end a second sweep over the
// same columns follows, then the verdict on a shared shift-add multiplier, one
// cycle per multiplier bit over six products.
// The result is registered once the verdict is done and out_ch is free; the next
// frame's items are taken while it waits for out_ch.ready. A frame that ends
// while the previous result still waits holds in_ch.ready low until transfer.
// Reset restores the register defaults and clears all per-frame sums, counters
// and detection state; line store contents are not cleared.
module frame_quality_gate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fqg_in_if.sink                       in_ch,
  fqg_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fqg_pkg::CFG_AW-1:0]   paddr,
  input  logic [fqg_pkg::CFG_DW-1:0]   pwdata,
  output logic [fqg_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RAW = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int GW  = NW + 8;
  localparam int CMW = (WW > 11) ? WW : 11;
  localparam int CMH = (HW > 11) ? HW : 11;

  typedef enum logic [4:0] {
    ST_RUN  = 5'b00001,
    ST_ROW  = 5'b00010,
    ST_TAIL = 5'b00100,
    ST_CALC = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Configuration registers
  logic [10:0] fw_r, fh_r;
  logic [7:0]  minb_r, maxb_r;
  logic [19:0] blur_r;
  logic [15:0] clo_r, chi_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  // Frame state
  state_t        state_r, state_nxt;
  logic [CAW-1:0] col_r;
  logic [RAW-1:0] row_r;
  logic [1:0]    slot_r;
  logic [GW-1:0] gray_total_r;
  logic [NW-1:0] gray_cnt_r;
  logic          seen_det_r, seen_unc_r, frame_end_r;
  logic [15:0]   kept_r;

  // Result register
  logic        out_vld_r, save_r;
  logic [2:0]  reason_r;
  logic [15:0] flag_r;

  logic [CMW-1:0] fw_ext, w_cl;
  logic [CMH-1:0] fh_ext, h_cl;
  logic [WW-1:0]  w;
  logic           in_acc, det_acc, pix_acc, col_last, row_last, in_window;
  logic [21:0]    gray_sum;
  logic [7:0]     gray;
  logic [1:0]     slot_p1, slot_m1;
  logic           sweep_go, calc_go, emit_load, frame_clear;
  fqg_pkg::sweep_rows_t sweep_rows;
  fqg_pkg::reason_t     reason;
  fqg_pkg::verdict_t    verdict;

  logic                 lap_done;
  logic signed [NW+10:0] lap_sum;
  logic [NW+19:0]       lap_sq;
  logic [NW-1:0]        lap_cnt;

  // APB write and read
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= fqg_pkg::RST_FRAME_WIDTH;
      fh_r   <= fqg_pkg::RST_FRAME_HEIGHT;
      minb_r <= fqg_pkg::RST_MIN_BRIGHTNESS;
      maxb_r <= fqg_pkg::RST_MAX_BRIGHTNESS;
      blur_r <= fqg_pkg::RST_MIN_BLUR;
      clo_r  <= fqg_pkg::RST_CONF_LOW;
      chi_r  <= fqg_pkg::RST_CONF_HIGH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fqg_pkg::REG_FRAME_WIDTH:    fw_r   <= pwdata[10:0];
        fqg_pkg::REG_FRAME_HEIGHT:   fh_r   <= pwdata[10:0];
        fqg_pkg::REG_MIN_BRIGHTNESS: minb_r <= pwdata[7:0];
        fqg_pkg::REG_MAX_BRIGHTNESS: maxb_r <= pwdata[7:0];
        fqg_pkg::REG_MIN_BLUR:       blur_r <= pwdata[19:0];
        fqg_pkg::REG_CONF_LOW:       clo_r  <= pwdata[15:0];
        fqg_pkg::REG_CONF_HIGH:      chi_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fqg_pkg::REG_FRAME_WIDTH:    prdata = 32'(fw_r);
      fqg_pkg::REG_FRAME_HEIGHT:   prdata = 32'(fh_r);
      fqg_pkg::REG_MIN_BRIGHTNESS: prdata = 32'(minb_r);
      fqg_pkg::REG_MAX_BRIGHTNESS: prdata = 32'(maxb_r);
      fqg_pkg::REG_MIN_BLUR:       prdata = 32'(blur_r);
      fqg_pkg::REG_CONF_LOW:       prdata = 32'(clo_r);
      fqg_pkg::REG_CONF_HIGH:      prdata = 32'(chi_r);
      default:                     prdata = '0;
    endcase
  end

  // Clamp geometry to [3, MAX]
  always_comb begin
    fw_ext = CMW'(fw_r);
    fh_ext = CMH'(fh_r);
    priority if (fw_ext < CMW'(3))         w_cl = CMW'(3);
    else if (fw_ext > CMW'(MAX_WIDTH))     w_cl = CMW'(MAX_WIDTH);
    else                                   w_cl = fw_ext;
    priority if (fh_ext < CMH'(3))         h_cl = CMH'(3);
    else if (fh_ext > CMH'(MAX_HEIGHT))    h_cl = CMH'(MAX_HEIGHT);
    else                                   h_cl = fh_ext;
  end
  assign w = WW'(w_cl);

  // Intake
  assign in_ch.ready = (state_r == ST_RUN);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign det_acc = in_acc && (in_ch.cmd == fqg_pkg::CMD_DETECTION);
  assign pix_acc = in_acc && (in_ch.cmd == fqg_pkg::CMD_PIXEL);
  assign in_window = (in_ch.det_conf >= clo_r) && (in_ch.det_conf <= chi_r);

  assign gray_sum = 22'(in_ch.pixel_red) * fqg_pkg::GRAY_K_RED
                  + 22'(in_ch.pixel_green) * fqg_pkg::GRAY_K_GREEN
                  + 22'(in_ch.pixel_blue) * fqg_pkg::GRAY_K_BLUE
                  + fqg_pkg::GRAY_ROUND;
  assign gray = gray_sum[21:14];

  assign col_last = !((CMW'(col_r) + CMW'(1)) < w_cl);
  assign row_last = !((CMH'(row_r) + CMH'(1)) < h_cl);
  assign slot_p1  = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
  assign slot_m1  = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;

  // Sweep requests: row end uses the row above, frame end reflects the last row
  always_comb begin
    sweep_go   = 1'b0;
    sweep_rows = '{up: slot_m1, mid: slot_r, dn: slot_m1};
    if (pix_acc && col_last && row_r != '0) begin
      sweep_go   = 1'b1;
      sweep_rows = '{up: (row_r == RAW'(1)) ? slot_r : slot_p1, mid: slot_m1, dn: slot_r};
    end else if (state_r == ST_ROW && lap_done && frame_end_r) begin
      sweep_go = 1'b1;
    end
  end

  assign calc_go     = (state_r == ST_TAIL) && lap_done;
  assign emit_load   = (state_r == ST_EMIT) && (!out_vld_r || out_ch.ready);
  assign frame_clear = emit_load;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:  if (pix_acc && col_last && row_r != '0) state_nxt = ST_ROW;
      ST_ROW:  if (lap_done) state_nxt = frame_end_r ? ST_TAIL : ST_RUN;
      ST_TAIL: if (lap_done) state_nxt = ST_CALC;
      ST_CALC: if (verdict.done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_load) state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  // Per-frame counters, sums and detection state
  always_ff @(posedge clk) begin
    if (!rst_n || frame_clear) begin
      state_r      <= rst_n ? state_nxt : ST_RUN;
      col_r        <= '0;
      row_r        <= '0;
      slot_r       <= '0;
      gray_total_r <= '0;
      gray_cnt_r   <= '0;
      seen_det_r   <= 1'b0;
      seen_unc_r   <= 1'b0;
      kept_r       <= '0;
      frame_end_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (det_acc) begin
        seen_det_r <= 1'b1;
        if (!seen_unc_r && in_window) begin
          seen_unc_r <= 1'b1;
          kept_r     <= in_ch.det_conf;
        end
      end
      if (pix_acc) begin
        gray_total_r <= gray_total_r + GW'(gray);
        gray_cnt_r   <= gray_cnt_r + NW'(1);
        if (!col_last) begin
          col_r <= col_r + CAW'(1);
        end else begin
          col_r <= '0;
          if (row_last) begin
            frame_end_r <= 1'b1;
          end else begin
            row_r  <= row_r + RAW'(1);
            slot_r <= slot_p1;
          end
        end
      end
    end
  end

  // Result choice
  always_comb begin
    priority if (seen_unc_r)  reason = fqg_pkg::REASON_UNCERTAIN;
    else if (!seen_det_r)     reason = fqg_pkg::REASON_CLEAR;
    else if (verdict.dark)    reason = fqg_pkg::REASON_TOO_DARK;
    else if (verdict.bright)  reason = fqg_pkg::REASON_TOO_BRIGHT;
    else if (verdict.blurry)  reason = fqg_pkg::REASON_BLURRY;
    else                      reason = fqg_pkg::REASON_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      save_r   <= (reason != fqg_pkg::REASON_CLEAR);
      reason_r <= reason;
      flag_r   <= seen_unc_r ? kept_r : 16'd0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.save_frame   = save_r;
  assign out_ch.reason_code  = reason_r;
  assign out_ch.flagged_conf = flag_r;

  fqg_lap #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_lap (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pix_acc),
    .wr_addr (col_r),
    .wr_slot (slot_r),
    .wr_data (gray),
    .go      (sweep_go),
    .rows    (sweep_rows),
    .width   (w),
    .clear   (frame_clear),
    .done    (lap_done),
    .lap_sum (lap_sum),
    .lap_sq  (lap_sq),
    .lap_cnt (lap_cnt)
  );

  fqg_decide #(
    .NW (NW)
  ) u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (calc_go),
    .gray_total (gray_total_r),
    .gray_cnt   (gray_cnt_r),
    .lap_sum    (lap_sum),
    .lap_sq     (lap_sq),
    .lap_cnt    (lap_cnt),
    .min_bright (minb_r),
    .max_bright (maxb_r),
    .min_blur   (blur_r),
    .verdict    (verdict)
  );

  a_lap_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    lap_done |-> (state_r == ST_ROW || state_r == ST_TAIL))
    else $error("sweep finished outside a wait state");
  a_verdict_expected: assert property (@(posedge clk) disable iff (!rst_n)
    verdict.done |-> state_r == ST_CALC)
    else $error("verdict outside calc state");
  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |=> (gray_total_r == '0 && row_r == '0 && !seen_det_r && out_vld_r))
    else $error("frame state not cleared on result load");
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("row slot out of range");

endmodule
